[sv/cps_pkg.sv]
package cps_pkg;

  localparam int unsigned OpW    = 3;
  localparam int unsigned PhaseW = 4;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned CountW = 8;
  localparam int unsigned CfgIdxW = 2;

  typedef logic [CountW-1:0] count_t;

  typedef enum logic [OpW-1:0] {
    OP_TICK         = 3'd0,
    OP_START_CHARGE = 3'd1,
    OP_START_DRIVE  = 3'd2,
    OP_STOP         = 3'd3,
    OP_ESTOP        = 3'd4,
    OP_ENABLE       = 3'd5
  } op_t;

  typedef enum logic [PhaseW-1:0] {
    PH_INIT      = 4'd0,
    PH_OFF       = 4'd1,
    PH_WAIT      = 4'd2,
    PH_PRECHARGE = 4'd3,
    PH_ACTIVATE  = 4'd4,
    PH_CHARGING  = 4'd5,
    PH_DRIVE     = 4'd6,
    PH_STOP      = 4'd7,
    PH_FAULT     = 4'd8
  } phase_t;

  typedef enum logic [ModeW-1:0] {
    MODE_OFF    = 2'd0,
    MODE_CHARGE = 2'd1,
    MODE_DCDC   = 2'd2
  } mode_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PRECHARGE = 2'd0,
    CFG_WAKEUP    = 2'd1,
    CFG_POWERDOWN = 2'd2
  } cfg_idx_t;

  localparam count_t PrechargeReset = 8'd50;
  localparam count_t WakeupReset    = 8'd5;
  localparam count_t PowerdownReset = 8'd20;

  typedef struct packed {
    logic  power_on;
    logic  charge_on;
    logic  dcdc_on;
    logic  link;
    mode_t mode;
    logic  charge_req;
  } flags_t;

  localparam flags_t FlagsOff = '{
    power_on:   1'b0,
    charge_on:  1'b0,
    dcdc_on:    1'b0,
    link:       1'b0,
    mode:       MODE_OFF,
    charge_req: 1'b0
  };

  typedef struct packed {
    logic [PhaseW-1:0] seq_state;
    logic              power_enable_pin;
    logic              charge_pin_n;
    logic              dcdc_pin_n;
    logic              link_enabled;
    logic [ModeW-1:0]  converter_mode;
    logic              charge_request;
    logic              power_zero_pulse;
    logic              heartbeat_burst;
    logic              command_refused;
  } result_t;

endpackage

[sv/cps_in_if.sv]
interface cps_in_if import cps_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [OpW-1:0] operation;
  logic           enable_value;

  modport source (output valid, output operation, output enable_value, input ready);
  modport sink   (input valid, input operation, input enable_value, output ready);
endinterface

[sv/cps_out_if.sv]
interface cps_out_if import cps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PhaseW-1:0] seq_state;
  logic              power_enable_pin;
  logic              charge_pin_n;
  logic              dcdc_pin_n;
  logic              link_enabled;
  logic [ModeW-1:0]  converter_mode;
  logic              charge_request;
  logic              power_zero_pulse;
  logic              heartbeat_burst;
  logic              command_refused;

  modport source (
    output valid, output seq_state, output power_enable_pin, output charge_pin_n,
    output dcdc_pin_n, output link_enabled, output converter_mode,
    output charge_request, output power_zero_pulse, output heartbeat_burst,
    output command_refused, input ready
  );
  modport sink (
    input valid, input seq_state, input power_enable_pin, input charge_pin_n,
    input dcdc_pin_n, input link_enabled, input converter_mode,
    input charge_request, input power_zero_pulse, input heartbeat_burst,
    input command_refused, output ready
  );
endinterface

[sv/cps_cfg_if.sv]
interface cps_cfg_if import cps_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CountW-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/converter_power_sequencer.sv]
// Power converter sequencer. Each transfer on the input channel carries one
// event (step tick, start charge, start drive, stop, emergency stop or manual
// enable) and produces exactly one result transfer on the output channel with
// the sequence state, pin levels, mode and the pulses caused by that event.
// The configuration channel writes the precharge, wakeup and powerdown tick
// counts; it is always ready and should only be used while the block is idle.
// The result is registered: the result of an event accepted at one edge is
// valid from the next. The whole state update is one pass of logic between
// the state registers and the result register, and the result register frees
// itself in the cycle it is taken, so input ready stays high and one event is
// accepted every cycle while the receiver keeps up. When the receiver stalls,
// the waiting result holds and input ready drops until it is taken.
// After reset the sequence is off, all flags and countdowns are clear, the
// tick counts take their default values and no result is pending.
module converter_power_sequencer
  import cps_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  cps_in_if.sink    in_if,
  cps_out_if.source out_if,
  cps_cfg_if.sink   cfg_if
);

  count_t  precharge_ticks_r;
  count_t  wakeup_ticks_r;
  count_t  powerdown_ticks_r;

  phase_t  phase_r, phase_nxt;
  phase_t  target_r, target_nxt;
  count_t  pc_cnt_r, pc_cnt_nxt;
  count_t  wk_cnt_r, wk_cnt_nxt;
  count_t  pd_cnt_r, pd_cnt_nxt;
  flags_t  flags_r, flags_nxt;
  logic    zero_pulse, burst, refused;

  result_t res_r, res_nxt;
  logic    out_valid_r;
  logic    accept;
  op_t     op;
  count_t  pc_dec;
  count_t  pd_dec;

  assign op     = op_t'(in_if.operation);
  assign accept = in_if.valid && in_if.ready;
  assign pc_dec = pc_cnt_r - 8'd1;
  assign pd_dec = pd_cnt_r - 8'd1;

  assign cfg_if.ready = 1'b1;
  assign in_if.ready  = !out_valid_r || out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      precharge_ticks_r <= PrechargeReset;
      wakeup_ticks_r    <= WakeupReset;
      powerdown_ticks_r <= PowerdownReset;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        CFG_PRECHARGE: precharge_ticks_r <= cfg_if.data;
        CFG_WAKEUP:    wakeup_ticks_r    <= cfg_if.data;
        CFG_POWERDOWN: powerdown_ticks_r <= cfg_if.data;
        default: ;
      endcase
    end
  end

  // Next sequence state.
  always_comb begin
    phase_nxt = phase_r;
    case (op)
      OP_TICK: begin
        case (phase_r)
          PH_INIT:      phase_nxt = PH_OFF;
          PH_OFF:       phase_nxt = PH_OFF;
          PH_WAIT:      phase_nxt = PH_PRECHARGE;
          PH_PRECHARGE: begin
            if ((flags_r.link || wk_cnt_r == '0) && pc_cnt_r == 8'd1) begin
              phase_nxt = PH_ACTIVATE;
            end
          end
          PH_ACTIVATE:  phase_nxt = target_r;
          PH_CHARGING, PH_DRIVE, PH_FAULT: phase_nxt = phase_r;
          PH_STOP: begin
            if (pd_cnt_r == 8'd1) begin
              phase_nxt = PH_OFF;
            end
          end
          default:      phase_nxt = PH_OFF;
        endcase
      end
      OP_START_CHARGE, OP_START_DRIVE: begin
        if (phase_r == PH_OFF) begin
          phase_nxt = PH_WAIT;
        end
      end
      OP_STOP:  phase_nxt = PH_STOP;
      OP_ESTOP: phase_nxt = PH_OFF;
      default: ;
    endcase
  end

  // Flags, countdowns, target and pulses.
  always_comb begin
    target_nxt = target_r;
    pc_cnt_nxt = pc_cnt_r;
    wk_cnt_nxt = wk_cnt_r;
    pd_cnt_nxt = pd_cnt_r;
    flags_nxt  = flags_r;
    zero_pulse = 1'b0;
    burst      = 1'b0;
    refused    = 1'b0;
    case (op)
      OP_TICK: begin
        case (phase_r)
          PH_OFF: begin
            flags_nxt  = FlagsOff;
            pc_cnt_nxt = precharge_ticks_r;
            wk_cnt_nxt = wakeup_ticks_r;
            pd_cnt_nxt = powerdown_ticks_r;
          end
          PH_PRECHARGE: begin
            flags_nxt.power_on = 1'b1;
            if (!flags_r.link && wk_cnt_r != '0) begin
              wk_cnt_nxt = wk_cnt_r - 8'd1;
            end else begin
              if (!flags_r.link) begin
                flags_nxt.link = 1'b1;
                burst          = 1'b1;
              end
              if (pc_cnt_r != '0) begin
                pc_cnt_nxt = pc_dec;
              end
            end
          end
          PH_ACTIVATE: begin
            if (target_r == PH_CHARGING) begin
              flags_nxt.charge_on  = 1'b1;
              flags_nxt.dcdc_on    = 1'b0;
              flags_nxt.mode       = MODE_CHARGE;
              flags_nxt.charge_req = 1'b1;
            end else if (target_r == PH_DRIVE) begin
              flags_nxt.charge_on  = 1'b0;
              flags_nxt.dcdc_on    = 1'b1;
              flags_nxt.mode       = MODE_DCDC;
              flags_nxt.charge_req = 1'b0;
            end
          end
          PH_DRIVE: begin
            flags_nxt.charge_on  = 1'b0;
            flags_nxt.dcdc_on    = 1'b1;
            flags_nxt.power_on   = 1'b1;
            flags_nxt.link       = 1'b1;
            flags_nxt.mode       = MODE_DCDC;
            flags_nxt.charge_req = 1'b0;
          end
          PH_STOP: begin
            zero_pulse = 1'b1;
            if (pd_cnt_r != '0) begin
              pd_cnt_nxt = pd_dec;
              if (pd_cnt_r == 8'd1) begin
                flags_nxt = FlagsOff;
              end
            end
          end
          PH_FAULT: flags_nxt = FlagsOff;
          default: ;
        endcase
      end
      OP_START_CHARGE, OP_START_DRIVE: begin
        if (phase_r == PH_OFF) begin
          target_nxt = (op == OP_START_CHARGE) ? PH_CHARGING : PH_DRIVE;
        end else begin
          refused = 1'b1;
        end
      end
      OP_ESTOP:  flags_nxt = FlagsOff;
      OP_ENABLE: flags_nxt.power_on = in_if.enable_value;
      default: ;
    endcase
  end

  always_comb begin
    res_nxt.seq_state        = phase_nxt;
    res_nxt.power_enable_pin = flags_nxt.power_on;
    res_nxt.charge_pin_n     = !flags_nxt.charge_on;
    res_nxt.dcdc_pin_n       = !flags_nxt.dcdc_on;
    res_nxt.link_enabled     = flags_nxt.link;
    res_nxt.converter_mode   = flags_nxt.mode;
    res_nxt.charge_request   = flags_nxt.charge_req;
    res_nxt.power_zero_pulse = zero_pulse;
    res_nxt.heartbeat_burst  = burst;
    res_nxt.command_refused  = refused;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_OFF;
      target_r    <= PH_OFF;
      pc_cnt_r    <= '0;
      wk_cnt_r    <= '0;
      pd_cnt_r    <= '0;
      flags_r     <= FlagsOff;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r     <= phase_nxt;
        target_r    <= target_nxt;
        pc_cnt_r    <= pc_cnt_nxt;
        wk_cnt_r    <= wk_cnt_nxt;
        pd_cnt_r    <= pd_cnt_nxt;
        flags_r     <= flags_nxt;
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_if.valid            = out_valid_r;
  assign out_if.seq_state        = res_r.seq_state;
  assign out_if.power_enable_pin = res_r.power_enable_pin;
  assign out_if.charge_pin_n     = res_r.charge_pin_n;
  assign out_if.dcdc_pin_n       = res_r.dcdc_pin_n;
  assign out_if.link_enabled     = res_r.link_enabled;
  assign out_if.converter_mode   = res_r.converter_mode;
  assign out_if.charge_request   = res_r.charge_request;
  assign out_if.power_zero_pulse = res_r.power_zero_pulse;
  assign out_if.heartbeat_burst  = res_r.heartbeat_burst;
  assign out_if.command_refused  = res_r.command_refused;

endmodule
